[hw/rtl/rscp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rscp_pkg
// Shared types and constants of the ring sequence claim/publish block.
// ----------------------------------------------------------------------------
package rscp_pkg;

	// field widths of the stream items
	localparam int CNT_W       = 11;
	localparam int ESIZE_W     = 9;
	localparam int BOFF_W      = 18;
	localparam int FSEQ_W      = 32;
	localparam int S_TDATA_W   = 48;
	localparam int S_TUSER_W   = 3;
	localparam int M_TDATA_W   = 104;
	localparam int M_TUSER_W   = 2;

	// configuration port
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 11;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_SIZE = 4'd1;

	// register reset values and the element size limit
	localparam logic [CNT_W-1:0]   SLOT_COUNT_RST   = 11'd1024;
	localparam logic [ESIZE_W-1:0] ELEMENT_SIZE_RST = 9'd4;
	localparam logic [ESIZE_W-1:0] ESIZE_MAX        = 9'd256;

	typedef enum logic [1:0] {
		ACT_CLAIM   = 2'd0,
		ACT_PUBLISH = 2'd1,
		ACT_CONSUME = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_NO_ROOM      = 2'd1,
		ST_OUT_OF_ORDER = 2'd2,
		ST_CLAMPED      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CALC,
		S_DIV,
		S_MUL,
		S_DONE
	} state_t;

endpackage

[hw/rtl/ring_sequence_claim_publish.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_sequence_claim_publish
// Claim/publish/consume sequencer for a ring of slots shared by producers
// and one consumer.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_* stream, one transaction per operation; the
//   action and truncation flag ride in s_tuser, count and range begin in
//   s_tdata. Each request yields exactly one result transaction on m_*,
//   with the status in m_tuser and the grant and readable range in m_tdata.
//   Slot count and element size are written through the cfg_* channel,
//   which is always ready; write them only while no request is in flight.
// Flow:
//   publish, consume and refused claims pass from S_CALC to S_DONE and
//   then load the output register. A granted claim adds the slot offset
//   remainder in S_DIV, worked out one sequence bit per cycle in a serial
//   unit, and then the byte offset multiply in S_MUL before S_DONE.
//   s_tready is high only while idle; one request is handled at a time.
// Reset:
//   all three counters clear to zero, slot count 1024, element size 4.
// Stall:
//   a result waits in the output register while m_tready is low; the next
//   request may be accepted meanwhile and completes up to the output
//   register, where it waits for the previous result to be taken.
// ----------------------------------------------------------------------------
module ring_sequence_claim_publish #(
	parameter int MAX_SLOTS = 1024,
	parameter int SEQ_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// request stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [rscp_pkg::S_TDATA_W-1:0]   s_tdata,  // count, range_begin
	input  logic [rscp_pkg::S_TUSER_W-1:0]   s_tuser,  // action, allow_truncation
	// result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// grant_begin, grant_count, byte_offset, avail_begin, avail_count
	output logic [rscp_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic [rscp_pkg::M_TUSER_W-1:0]   m_tuser,  // status
	// configuration writes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rscp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rscp_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import rscp_pkg::*;

	localparam int W = SEQ_WIDTH;
	localparam logic [CNT_W-1:0] SLOT_CAP =
		(MAX_SLOTS > ((1 << CNT_W) - 1)) ? CNT_W'((1 << CNT_W) - 1) : CNT_W'(MAX_SLOTS);

	state_t state_q, state_d;

	// configuration and counters
	logic [CNT_W-1:0]   slot_count_q;
	logic [ESIZE_W-1:0] element_size_q;
	logic [W-1:0]       claimed_q;
	logic [W-1:0]       published_q;
	logic [W-1:0]       consumed_q;

	// latched request
	logic [1:0]         action_q;
	logic [CNT_W-1:0]   count_q;
	logic               trunc_q;
	logic [FSEQ_W-1:0]  rbegin_q;

	// result under construction
	status_t            status_q;
	logic [W-1:0]       gbegin_q;
	logic [CNT_W-1:0]   gcount_q;
	logic [BOFF_W-1:0]  boff_q;

	// output register
	logic               m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic [M_TUSER_W-1:0] m_tuser_q;

	// control from the sequencer and the remainder unit
	logic               rem_start;
	logic               load_out;
	logic               rem_done;
	logic [CNT_W-1:0]   rem;

	// effective register values
	logic [CNT_W-1:0]   slots;
	logic [ESIZE_W-1:0] esize;
	logic [W-1:0]       slots_w;

	// operation evaluation
	logic [W-1:0]       free_cnt;
	logic [CNT_W-1:0]   claim_n;
	logic               claim_ok;
	logic [CNT_W-1:0]   grant;
	logic [W-1:0]       rbegin_w;
	logic [W-1:0]       pend;
	logic [W-1:0]       avail_w;
	logic               over;
	logic [W-1:0]       cons_step;
	logic [CNT_W-1:0]   avail_cnt;
	logic [CNT_W+ESIZE_W-1:0] offset_prod;

	// clamp out-of-range register values
	always_comb begin
		slots = slot_count_q;
		if (slots == '0) slots = CNT_W'(1);
		if (slots > SLOT_CAP) slots = SLOT_CAP;
		esize = element_size_q;
		if (esize == '0) esize = ESIZE_W'(1);
		if (esize > ESIZE_MAX) esize = ESIZE_MAX;
		slots_w = W'(slots);
	end

	// claim, publish and consume decisions on the current counters
	always_comb begin
		free_cnt = consumed_q + slots_w - claimed_q;
		claim_n  = (count_q > slots) ? slots : count_q;
		claim_ok = 1'b1;
		grant    = claim_n;
		if (!free_cnt[W-1] && (free_cnt >= W'(claim_n))) begin
			grant = claim_n;
		end else if (free_cnt[W-1] || (free_cnt == '0) || !trunc_q) begin
			claim_ok = 1'b0;
			grant    = '0;
		end else begin
			grant = free_cnt[CNT_W-1:0];
		end

		rbegin_w  = W'(rbegin_q);
		pend      = published_q - consumed_q;
		avail_w   = pend[W-1] ? '0 : pend;
		over      = W'(count_q) > avail_w;
		cons_step = over ? avail_w : W'(count_q);

		// readable amount reported in the result
		if (pend[W-1]) begin
			avail_cnt = '0;
		end else if (pend > slots_w) begin
			avail_cnt = slots;
		end else begin
			avail_cnt = pend[CNT_W-1:0];
		end

		offset_prod = rem * esize;
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and control
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		rem_start = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = S_CALC;
			end
			S_CALC: begin
				if ((action_q == ACT_CLAIM) && claim_ok) begin
					rem_start = 1'b1;
					state_d   = S_DIV;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DIV: begin
				if (rem_done) state_d = S_MUL;
			end
			S_MUL: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q   <= SLOT_COUNT_RST;
			element_size_q <= ELEMENT_SIZE_RST;
		end else if (cfg_valid) begin
			if (cfg_index == REG_SLOT_COUNT) begin
				slot_count_q <= cfg_data[CNT_W-1:0];
			end else if (cfg_index == REG_ELEMENT_SIZE) begin
				element_size_q <= cfg_data[ESIZE_W-1:0];
			end
		end
	end

	assign cfg_ready = 1'b1;

	// sequence counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			claimed_q   <= '0;
			published_q <= '0;
			consumed_q  <= '0;
		end else if (state_q == S_CALC) begin
			case (action_q)
				ACT_CLAIM: begin
					if (claim_ok) claimed_q <= claimed_q + W'(grant);
				end
				ACT_PUBLISH: begin
					if (published_q == rbegin_w) published_q <= rbegin_w + W'(count_q);
				end
				ACT_CONSUME: begin
					consumed_q <= consumed_q + cons_step;
				end
				default: begin
				end
			endcase
		end
	end

	// request capture and result fields
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_q <= s_tuser[1:0];
			trunc_q  <= s_tuser[2];
			count_q  <= s_tdata[CNT_W-1:0];
			rbegin_q <= s_tdata[CNT_W+FSEQ_W-1:CNT_W];
		end
		if (state_q == S_CALC) begin
			status_q <= ST_OK;
			gbegin_q <= '0;
			gcount_q <= '0;
			boff_q   <= '0;
			case (action_q)
				ACT_CLAIM: begin
					if (claim_ok) begin
						gbegin_q <= claimed_q;
						gcount_q <= grant;
					end else begin
						status_q <= ST_NO_ROOM;
					end
				end
				ACT_PUBLISH: begin
					if (published_q != rbegin_w) status_q <= ST_OUT_OF_ORDER;
				end
				ACT_CONSUME: begin
					if (over) status_q <= ST_CLAMPED;
				end
				default: begin
				end
			endcase
		end
		if (state_q == S_MUL) begin
			boff_q <= offset_prod[BOFF_W-1:0];
		end
	end

	// slot offset of the grant, started on the claimed counter before it moves
	rscp_rem_unit #(
		.DIVIDEND_W(W)
	) u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (rem_start),
		.dividend(claimed_q),
		.divisor (slots),
		.done    (rem_done),
		.rem     (rem)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tuser_q <= status_q;
			m_tdata_q <= {avail_cnt, FSEQ_W'(consumed_q), boff_q, gcount_q, FSEQ_W'(gbegin_q)};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// a refused claim carries no grant
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == ST_NO_ROOM)) |->
			(m_tdata[FSEQ_W+CNT_W+BOFF_W-1:0] == '0))
		else $error("refused claim reports a grant");

	// readable amount never exceeds the slot count
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[M_TDATA_W-1:M_TDATA_W-CNT_W] <= slots))
		else $error("avail_count above slot count");

	// remainder stays below the divisor
	assert property (@(posedge clk) disable iff (!arst_n)
		rem_done |-> (rem < slots))
		else $error("slot remainder out of range");

	// one request at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while busy");

endmodule

[hw/rtl/rscp_rem_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rscp_rem_unit
// Bit-serial remainder of a sequence number by the slot count, one
// dividend bit per cycle, restoring compare and subtract.
// ----------------------------------------------------------------------------
module rscp_rem_unit #(
	parameter int DIVIDEND_W = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [DIVIDEND_W-1:0]     dividend,
	input  logic [rscp_pkg::CNT_W-1:0] divisor,
	output logic                      done,
	output logic [rscp_pkg::CNT_W-1:0] rem
);
	import rscp_pkg::*;

	localparam int ITER_W = $clog2(DIVIDEND_W + 1);

	logic [ITER_W-1:0]     iter_q;
	logic                  done_q;
	logic [DIVIDEND_W-1:0] dividend_q;
	logic [CNT_W-1:0]      divisor_q;
	logic [CNT_W-1:0]      rem_q;
	logic [CNT_W:0]        trial;
	logic [CNT_W:0]        step_rem;

	// one restoring step: shift in the next dividend bit
	always_comb begin
		trial = {rem_q, dividend_q[DIVIDEND_W-1]};
		if (trial >= {1'b0, divisor_q}) begin
			step_rem = trial - {1'b0, divisor_q};
		end else begin
			step_rem = trial;
		end
	end

	// iteration counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (iter_q == ITER_W'(1));
			if (start) begin
				iter_q <= ITER_W'(DIVIDEND_W);
			end else if (iter_q != '0) begin
				iter_q <= iter_q - ITER_W'(1);
			end
		end
	end

	// operand and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			dividend_q <= dividend;
			divisor_q  <= divisor;
			rem_q      <= '0;
		end else if (iter_q != '0) begin
			dividend_q <= dividend_q << 1;
			rem_q      <= step_rem[CNT_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule
